// File: sv/rtc_pkg.sv
// Package for the real-time clock/calendar: request and result structs,
// counter state, command codes and the month-length table. No dependencies.

package rtc_pkg;

  // Width of the free-running tick total
  localparam int TOTAL_TICK_WIDTH = 32;

  localparam logic [7:0] TPS_RESET = 8'd16;

  // Command codes
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_LOAD_TIME = 2'd1;
  localparam logic [1:0] CMD_LOAD_DATE = 2'd2;

  // Last value of each counter before it wraps
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [3:0] MONTH_LAST = 4'd12;

  // Multiplicative inverse of 25 mod 2^16, and the largest product that
  // marks an exact multiple of 25 (65535 / 25)
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  load_hours;
    logic [5:0]  load_minutes;
    logic [5:0]  load_seconds;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } rtc_in_t;

  typedef struct packed {
    logic [5:0]  out_seconds;
    logic [5:0]  out_minutes;
    logic [4:0]  out_hours;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
    logic [31:0] out_total_ticks;
  } rtc_out_t;

  typedef struct packed {
    logic [7:0]                  tick_phase;
    logic [TOTAL_TICK_WIDTH-1:0] tick_total;
    logic [5:0]                  sec_count;
    logic [5:0]                  min_count;
    logic [4:0]                  hour_count;
    logic [4:0]                  day_count;
    logic [3:0]                  month_count;
    logic [15:0]                 year_count;
  } rtc_state_t;

  // Days in a non-leap month; invalid months count as 31
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2:    n = 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: sv/rtc_in_reg.sv
// Input register stage: holds one request until the update stage takes it.
// Depends on rtc_pkg.

module rtc_in_reg import rtc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  rtc_in_t in_data,
  output logic    req_valid,
  output rtc_in_t req_data,
  input  logic    req_take
);

  logic    valid_r;
  rtc_in_t data_r;

  // Free slot, or the held request leaves this cycle
  assign in_ready  = !valid_r || req_take;
  assign req_valid = valid_r;
  assign req_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// File: sv/rtc_advance.sv
// Next-state logic: applies one request (tick or load) to the counters,
// carrying through seconds, minutes, hours, day, month and year.
// Depends on rtc_pkg.

module rtc_advance import rtc_pkg::*; (
  input  rtc_state_t cur,
  input  rtc_in_t    req,
  input  logic [7:0] tps,
  output rtc_state_t nxt
);

  logic [8:0]  phase_inc;
  logic        sec_step;
  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;
  logic        day_wrap;
  logic [15:0] y_prod;
  logic        div25;
  logic        leap;
  logic [4:0]  dim;

  // Leap year: multiple of 4, and not of 100 unless of 400.
  // Divisibility by 25 via multiply by the modular inverse.
  assign y_prod = 16'(cur.year_count * INV25);
  assign div25  = (y_prod <= DIV25_MAX);
  assign leap   = (cur.year_count[1:0] == 2'b00) &&
                  (!div25 || (cur.year_count[3:0] == 4'b0000));

  always_comb begin
    dim = month_len(cur.month_count);
    if (cur.month_count == 4'd2 && leap) begin
      dim = 5'd29;
    end
  end

  // Carry chain
  assign phase_inc = {1'b0, cur.tick_phase} + 9'd1;
  assign sec_step  = (phase_inc >= {1'b0, tps});
  assign sec_wrap  = (cur.sec_count >= SEC_LAST);
  assign min_wrap  = (cur.min_count >= MIN_LAST);
  assign hour_wrap = (cur.hour_count >= HOUR_LAST);
  assign day_wrap  = (cur.day_count >= dim);

  always_comb begin
    nxt = cur;
    case (req.cmd)
      CMD_TICK: begin
        nxt.tick_total = cur.tick_total + 1'b1;
        if (sec_step) begin
          nxt.tick_phase = 8'd0;
          nxt.sec_count  = sec_wrap ? 6'd0 : cur.sec_count + 6'd1;
          if (sec_wrap) begin
            nxt.min_count = min_wrap ? 6'd0 : cur.min_count + 6'd1;
            if (min_wrap) begin
              nxt.hour_count = hour_wrap ? 5'd0 : cur.hour_count + 5'd1;
              if (hour_wrap) begin
                nxt.day_count = day_wrap ? 5'd1 : cur.day_count + 5'd1;
                if (day_wrap) begin
                  if (cur.month_count >= MONTH_LAST) begin
                    nxt.month_count = 4'd1;
                    nxt.year_count  = cur.year_count + 16'd1;
                  end else begin
                    nxt.month_count = cur.month_count + 4'd1;
                  end
                end
              end
            end
          end
        end else begin
          nxt.tick_phase = phase_inc[7:0];
        end
      end
      CMD_LOAD_TIME: begin
        nxt.hour_count = req.load_hours;
        nxt.min_count  = req.load_minutes;
        nxt.sec_count  = req.load_seconds;
      end
      CMD_LOAD_DATE: begin
        nxt.day_count   = req.load_day;
        nxt.month_count = req.load_month;
        nxt.year_count  = req.load_year;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: sv/rtc_calendar_counter_top.sv
// Real-time clock/calendar top: input register, counter state, result register.
// Depends on rtc_pkg, rtc_in_reg and rtc_advance.
// A request passes the input register, then the state and result registers.
// Throughput: one request per cycle with out_ready high; combinational carry chain.
// Reset (rst_n low, synchronous): time 00:00:00, date day 1 month 1 year 0,
// tick phase and total cleared, ticks_per_second 16, both stages empty.

module rtc_calendar_counter_top import rtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rtc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rtc_out_t   out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic       tps_r;
  logic [7:0] tps_val_r;
  logic       req_valid;
  rtc_in_t    req_data;
  logic       req_take;
  rtc_state_t state_r;
  rtc_state_t state_nxt;
  logic       out_valid_r;
  rtc_out_t   out_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= 1'b0;
      tps_val_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r     <= 1'b1;
      tps_val_r <= cfg_wdata;
    end
  end

  rtc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req_data  (req_data),
    .req_take  (req_take)
  );

  rtc_advance u_advance (
    .cur (state_r),
    .req (req_data),
    .tps (tps_val_r),
    .nxt (state_nxt)
  );

  // Update when a request is held and the result slot is free or draining
  assign req_take = req_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{tick_phase:  8'd0,
                   tick_total:  '0,
                   sec_count:   6'd0,
                   min_count:   6'd0,
                   hour_count:  5'd0,
                   day_count:   5'd1,
                   month_count: 4'd1,
                   year_count:  16'd0};
    end else if (req_take) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      out_r <= '{out_seconds:     state_nxt.sec_count,
                 out_minutes:     state_nxt.min_count,
                 out_hours:       state_nxt.hour_count,
                 out_day:         state_nxt.day_count,
                 out_month:       state_nxt.month_count,
                 out_year:        state_nxt.year_count,
                 out_total_ticks: 32'(state_nxt.tick_total)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> out_valid_r)
    else $error("update without a result");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && req_data.cmd == CMD_TICK) |=>
      state_r.tick_total == TOTAL_TICK_WIDTH'($past(state_r.tick_total) + 1'b1))
    else $error("tick total did not advance by one");

  a_load_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && req_data.cmd != CMD_TICK) |=>
      ($stable(state_r.tick_total) && $stable(state_r.tick_phase)))
    else $error("non-tick request changed the tick counters");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !req_take |=> $stable(state_r))
    else $error("state changed without a request");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.out_year == state_r.year_count &&
                     out_r.out_seconds == state_r.sec_count))
    else $error("result out of step with counter state");

  a_cfg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> tps_r)
    else $error("configuration write not recorded");

endmodule
